// File: rtl/tsc_pkg.sv
// Package for the task scheduler: types, codes and defaults.
// Used by task_scheduler_with_channels, tsc_ctrl and tsc_dp.
package tsc_pkg;

    localparam int SlotsDefault        = 16;
    localparam int ChannelsDefault     = 4;
    localparam int ChannelDepthDefault = 16;
    localparam int MessageWidthDefault = 32;
    localparam logic [4:0] CapReset    = 5'd16;

    typedef enum logic [2:0] {
        K_START    = 3'd0,
        K_DISPATCH = 3'd1,
        K_YIELD    = 3'd2,
        K_FINISH   = 3'd3,
        K_SEND     = 3'd4,
        K_RECEIVE  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_OK        = 3'd0,
        S_NO_FREE   = 3'd1,
        S_EMPTY     = 3'd2,
        S_BLOCKED   = 3'd3,
        S_NO_RUN    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_BLOCKED = 2'd3
    } t_slot_st;

    typedef enum logic [1:0] {
        F_IDLE = 2'd0,
        F_EXEC = 2'd1,
        F_OUT  = 2'd2
    } t_fsm;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  channel;
        logic [31:0] message;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [31:0] received;
        logic        woke_valid;
        logic [3:0]  woke_slot;
    } t_out;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

endpackage

// File: rtl/task_scheduler_with_channels.sv
// Task scheduler with bounded message channels: one result per event,
// each event passing through accept, execute with message RAM access and
// result register, plus output wait; a new event is taken only once the
// last result is accepted. Configuration writes are accepted at any cycle.
// Depends on tsc_pkg, tsc_ctrl, tsc_dp, tsc_ram.
module task_scheduler_with_channels
    import tsc_pkg::*;
#(
    parameter int SLOTS = SlotsDefault,
    parameter int CHANNELS = ChannelsDefault,
    parameter int CHANNEL_DEPTH = ChannelDepthDefault,
    parameter int MESSAGE_WIDTH = MessageWidthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data
);
    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    tsc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_cmd(cmd)
    );

    tsc_dp #(
        .SLOTS(SLOTS), .CHANNELS(CHANNELS),
        .CHANNEL_DEPTH(CHANNEL_DEPTH), .MESSAGE_WIDTH(MESSAGE_WIDTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .i_in(i_in_data),
        .i_cfg_we(i_cfg_valid), .i_cfg_data(i_cfg_data),
        .o_out(o_out_data)
    );
endmodule

// File: rtl/tsc_ram.sv
// Generic single-port RAM with registered read and read enable.
// No dependencies.
module tsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_addr];
    end
endmodule

// File: rtl/tsc_ctrl.sv
// Controller: handshake sequencing IDLE -> EXEC -> OUT.
// Depends on tsc_pkg.
module tsc_ctrl
    import tsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);
    t_fsm r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= F_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            F_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = F_EXEC;
                end
            end
            F_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = F_OUT;
            end
            F_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end
endmodule

// File: rtl/tsc_dp.sv
// Datapath: slot table, run queue, channel pointers, waiters, message RAM.
// Depends on tsc_pkg and tsc_ram.
module tsc_dp
    import tsc_pkg::*;
#(
    parameter int SLOTS = SlotsDefault,
    parameter int CHANNELS = ChannelsDefault,
    parameter int CHANNEL_DEPTH = ChannelDepthDefault,
    parameter int MESSAGE_WIDTH = MessageWidthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_in        i_in,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    output t_out       o_out
);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW = $clog2(CHANNEL_DEPTH);
    localparam int FW = PW + 1;
    localparam int AW = CW + PW;

    logic [4:0]  r_cap;
    t_slot_st    r_st [SLOTS];
    logic [SW-1:0] r_q [SLOTS];
    logic [SW-1:0] r_head, r_tail;
    logic [SW:0]   r_cnt;
    logic          r_run_v;
    logic [SW-1:0] r_run;
    logic [PW-1:0] r_rp [CHANNELS];
    logic [PW-1:0] r_wp [CHANNELS];
    logic [FW-1:0] r_fill [CHANNELS];
    logic          r_rwv [CHANNELS];
    logic [SW-1:0] r_rws [CHANNELS];
    logic          r_swv [CHANNELS];
    logic [SW-1:0] r_sws [CHANNELS];
    t_in           r_in;
    t_out          r_res;
    logic          r_rd;

    logic [CW-1:0] ch;
    logic [FW-1:0] capu;
    logic [FW-1:0] fill;
    logic [SW-1:0] freei;
    logic          freef;
    logic          is_send_ok, is_recv_ok, ram_we;
    logic [PW-1:0] ptr;
    logic [AW-1:0] addr;
    logic [MESSAGE_WIDTH-1:0] wdata, rdata;
    logic [MESSAGE_WIDTH-1:0] msg_src;

    // channel index wraps modulo CHANNELS; the field is only two bits wide
    always_comb begin
        logic [3:0] t;
        t = {2'b00, r_in.channel};
        for (int k = 0; k < 3; k++) begin
            if (int'(t) >= CHANNELS) t = t - 4'(CHANNELS);
        end
        ch = CW'(t);
    end

    always_comb begin
        if (r_cap == 5'd0) capu = FW'(1);
        else if (int'(r_cap) > CHANNEL_DEPTH) capu = FW'(CHANNEL_DEPTH);
        else capu = FW'(r_cap);
    end

    assign fill = r_fill[ch];

    always_comb begin
        freef = 1'b0;
        freei = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_st[i] == ST_FREE) begin
                freef = 1'b1;
                freei = SW'(i);
            end
        end
    end

    assign is_send_ok = t_kind'(r_in.kind) == K_SEND && r_run_v && fill < capu;
    assign is_recv_ok = t_kind'(r_in.kind) == K_RECEIVE && r_run_v && fill != '0;
    assign ptr = is_send_ok ? r_wp[ch] : r_rp[ch];
    assign ram_we = i_cmd.exec && is_send_ok;
    assign msg_src = MESSAGE_WIDTH'(r_in.message);
    assign wdata = msg_src;
    assign addr = AW'({ch, ptr});

    tsc_ram #(.WIDTH(MESSAGE_WIDTH), .DEPTH(2 ** AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (i_cmd.exec),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [FW-1:0] c);
        logic [FW-1:0] n;
        n = FW'(p) + FW'(1);
        return (n >= c) ? '0 : n[PW-1:0];
    endfunction

    function automatic logic [SW-1:0] qinc(input logic [SW-1:0] p);
        return (p == SW'(SLOTS - 1)) ? '0 : p + SW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_in <= i_in;
        if (i_cmd.exec) r_rd <= is_recv_ok;
    end

    // result; received comes from RAM, held there until the next exec
    always_comb begin
        o_out = r_res;
        if (r_rd) o_out.received = 32'(rdata);
    end

    always_ff @(posedge i_clk) begin
        logic [SW-1:0] cur, s;
        logic          wv;
        logic [SW-1:0] ws;
        logic [SW-1:0] tl;
        logic [SW:0]   cn;
        t_out          res;
        if (!i_rst_n) begin
            r_cap   <= CapReset;
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
            r_run_v <= 1'b0;
            r_run   <= '0;
            for (int i = 0; i < SLOTS; i++) r_st[i] <= ST_FREE;
            for (int c = 0; c < CHANNELS; c++) begin
                r_rp[c] <= '0; r_wp[c] <= '0; r_fill[c] <= '0;
                r_rwv[c] <= 1'b0; r_swv[c] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (i_cmd.exec) begin
                cur = r_run;
                tl = r_tail;
                cn = r_cnt;
                wv = 1'b0;
                ws = '0;
                res = '0;
                if (r_in.kind >= K_YIELD && r_in.kind <= K_RECEIVE && !r_run_v) begin
                    res.status = S_NO_RUN;
                end else begin
                    case (t_kind'(r_in.kind))
                        K_START: begin
                            if (freef) begin
                                r_st[freei] <= ST_READY;
                                r_q[r_tail] <= freei;
                                r_tail <= qinc(r_tail);
                                r_cnt <= r_cnt + 1'b1;
                                res.slot = 4'(freei);
                            end else res.status = S_NO_FREE;
                        end
                        K_DISPATCH: begin
                            if (r_run_v) res.slot = 4'(cur);
                            else if (r_cnt == '0) res.status = S_EMPTY;
                            else begin
                                s = r_q[r_head];
                                r_head <= qinc(r_head);
                                r_cnt <= r_cnt - 1'b1;
                                r_st[s] <= ST_RUNNING;
                                r_run_v <= 1'b1;
                                r_run <= s;
                                res.slot = 4'(s);
                            end
                        end
                        K_YIELD: begin
                            r_st[cur] <= ST_READY;
                            r_q[r_tail] <= cur;
                            r_tail <= qinc(r_tail);
                            r_cnt <= r_cnt + 1'b1;
                            r_run_v <= 1'b0;
                            res.slot = 4'(cur);
                        end
                        K_FINISH: begin
                            r_st[cur] <= ST_FREE;
                            r_run_v <= 1'b0;
                            res.slot = 4'(cur);
                        end
                        K_SEND: begin
                            res.slot = 4'(cur);
                            if (!is_send_ok) begin
                                r_swv[ch] <= 1'b1;
                                r_sws[ch] <= cur;
                                r_st[cur] <= ST_BLOCKED;
                                r_run_v <= 1'b0;
                                res.status = S_BLOCKED;
                            end else begin
                                r_wp[ch] <= adv(r_wp[ch], capu);
                                r_fill[ch] <= fill + FW'(1);
                                if (r_rwv[ch]) begin
                                    r_rwv[ch] <= 1'b0;
                                    if (r_st[r_rws[ch]] == ST_BLOCKED) begin
                                        wv = 1'b1; ws = r_rws[ch];
                                    end
                                end
                            end
                        end
                        K_RECEIVE: begin
                            res.slot = 4'(cur);
                            if (!is_recv_ok) begin
                                r_rwv[ch] <= 1'b1;
                                r_rws[ch] <= cur;
                                r_st[cur] <= ST_BLOCKED;
                                r_run_v <= 1'b0;
                                res.status = S_BLOCKED;
                            end else begin
                                r_rp[ch] <= adv(r_rp[ch], capu);
                                r_fill[ch] <= fill - FW'(1);
                                if (r_swv[ch]) begin
                                    r_swv[ch] <= 1'b0;
                                    if (r_st[r_sws[ch]] == ST_BLOCKED) begin
                                        wv = 1'b1; ws = r_sws[ch];
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                if (wv) begin
                    r_st[ws] <= ST_READY;
                    r_q[tl] <= ws;
                    r_tail <= qinc(tl);
                    r_cnt <= cn + 1'b1;
                    res.woke_valid = 1'b1;
                    res.woke_slot = 4'(ws);
                end
                r_res <= res;
            end
        end
    end
endmodule
